>>> hw/rtl/eia_pkg.sv
// Package for the extended integer ALU: widths, opcodes, class tags,
// error codes and the record that travels down the pipeline. No dependencies.
`default_nettype none
package eia_pkg;

	localparam int WIDTH = 64;
	localparam int DIV_STEPS = WIDTH;

	localparam logic [WIDTH-1:0] MIN_VAL = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4,
		OP_LESS = 3'd5,
		OP_EQ = 3'd6,
		OP_NOP = 3'd7
	} kind_t;

	localparam logic [1:0] TAG_FIN = 2'd0;
	localparam logic [1:0] TAG_POS = 2'd1;
	localparam logic [1:0] TAG_NEG = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OVF = 2'd1;
	localparam logic [1:0] ERR_UNDEF = 2'd2;
	localparam logic [1:0] ERR_DIV0 = 2'd3;

	// per-request record; value/tag/cmp/err hold the result unless a
	// later stage (multiplier, divider) replaces it
	typedef struct packed {
		logic op_mul;
		logic op_div;
		logic op_rem;
		logic neg_res;
		logic neg_a;
		logic [WIDTH-1:0] value;
		logic [1:0] tag;
		logic cmp;
		logic [1:0] err;
		logic [WIDTH-1:0] ua;
		logic [WIDTH-1:0] ub;
		logic [WIDTH-1:0] rr;
	} pipe_t;

endpackage
`default_nettype wire

>>> hw/rtl/eia_in_if.sv
// Request channel of the extended integer ALU: valid/ready plus operands.
// Depends on eia_pkg.
`default_nettype none
interface eia_in_if import eia_pkg::*; ();
	logic valid;
	logic ready;
	logic [2:0] kind;
	logic signed [WIDTH-1:0] a_value;
	logic [1:0] a_tag;
	logic signed [WIDTH-1:0] b_value;
	logic [1:0] b_tag;

	modport source (output valid, kind, a_value, a_tag, b_value, b_tag, input ready);
	modport sink (input valid, kind, a_value, a_tag, b_value, b_tag, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/eia_out_if.sv
// Result channel of the extended integer ALU: valid/ready plus result fields.
// Depends on eia_pkg.
`default_nettype none
interface eia_out_if import eia_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [WIDTH-1:0] res_value;
	logic [1:0] res_tag;
	logic cmp_true;
	logic [1:0] error_code;

	modport source (output valid, res_value, res_tag, cmp_true, error_code, input ready);
	modport sink (input valid, res_value, res_tag, cmp_true, error_code, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/extended_integer_alu.sv
// Extended integer ALU top level: decode, multiplier, divider chain and
// output register. Depends on eia_pkg, eia_in_if, eia_out_if, eia_decode,
// eia_mul and eia_div_step.
//
// Usage:
//  - req carries one request per valid/ready handshake: opcode, two
//    operands each with a class tag (finite, +inf, -inf).
//  - rsp returns exactly one result per request, in request order:
//    value, class tag, compare outcome and error code.
//  - The path from request to result is 1 decode stage, 4 multiplier
//    stages, 64 division steps (one quotient bit per stage) and 1 output
//    stage. Every opcode takes the same path, so order holds.
//  - Throughput is one request per cycle while the output is not stalled; the division chain sets the depth.
//  - The whole pipeline advances together. When rsp.ready is low with a
//    result waiting, every stage holds and req.ready drops; otherwise
//    req.ready stays high, including while the output register is empty.
//  - Reset clears every stage valid bit; the pipeline comes out empty and
//    ready.
`default_nettype none
module extended_integer_alu import eia_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	eia_in_if.sink req,
	eia_out_if.source rsp
);
	logic en;
	logic vld_dec, vld_mul;
	pipe_t rec_dec, rec_mul;
	logic div_vld [0:DIV_STEPS];
	pipe_t div_rec [0:DIV_STEPS];
	pipe_t last;
	logic [WIDTH-1:0] mag, fixed;
	logic neg;

	logic out_vld_q;
	logic [WIDTH-1:0] value_q;
	logic [1:0] tag_q;
	logic cmp_q;
	logic [1:0] err_q;

	// global advance: move when the output slot is free or being drained
	assign en = !out_vld_q || rsp.ready;
	assign req.ready = en;

	eia_decode u_decode (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(req.valid),
		.kind(req.kind), .a_value(req.a_value), .a_tag(req.a_tag),
		.b_value(req.b_value), .b_tag(req.b_tag),
		.vld_s1(vld_dec), .rec_s1(rec_dec)
	);

	eia_mul u_mul (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_dec), .rec_i(rec_dec),
		.vld_s4(vld_mul), .rec_s4(rec_mul)
	);

	assign div_vld[0] = vld_mul;
	assign div_rec[0] = rec_mul;

	// one quotient bit per stage, MSB first
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		eia_div_step u_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(div_vld[i]), .rec_i(div_rec[i]),
			.vld_s1(div_vld[i+1]), .rec_s1(div_rec[i+1])
		);
	end

	// sign fixup: quotient takes the product sign, remainder the dividend sign
	always_comb begin
		last = div_rec[DIV_STEPS];
		mag = last.op_rem ? last.rr : last.ua;
		neg = last.op_rem ? last.neg_a : last.neg_res;
		fixed = neg ? (~mag + 1'b1) : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= div_vld[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= last.op_div ? fixed : last.value;
			tag_q <= last.tag;
			cmp_q <= last.cmp;
			err_q <= last.err;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.res_value = value_q;
	assign rsp.res_tag = tag_q;
	assign rsp.cmp_true = cmp_q;
	assign rsp.error_code = err_q;
endmodule
`default_nettype wire

>>> hw/rtl/eia_decode.sv
// First stage: class handling, add/sub, compares, all error cases but multiply
// overflow, and the operand magnitudes for the multiplier and divider. Depends on eia_pkg.
`default_nettype none
module eia_decode import eia_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vld_i,
	input wire logic [2:0] kind,
	input wire logic [WIDTH-1:0] a_value,
	input wire logic [1:0] a_tag,
	input wire logic [WIDTH-1:0] b_value,
	input wire logic [1:0] b_tag,
	output logic vld_s1,
	output pipe_t rec_s1
);
	logic [WIDTH-1:0] a, b, sum, dif;
	logic a_fin, b_fin, a_neg, b_neg, b_zero, a_zero;
	pipe_t r;

	function automatic logic [1:0] flip(input logic [1:0] t);
		return (t == TAG_POS) ? TAG_NEG : TAG_POS;
	endfunction

	always_comb begin
		a_fin = (a_tag == TAG_FIN);
		b_fin = (b_tag == TAG_FIN);
		a = a_fin ? a_value : '0;
		b = b_fin ? b_value : '0;
		a_neg = a[WIDTH-1];
		b_neg = b[WIDTH-1];
		a_zero = (a == '0);
		b_zero = (b == '0);
		sum = a + b;
		dif = a - b;

		r = '0;
		r.ua = a_neg ? (~a + 1'b1) : a;
		r.ub = b_neg ? (~b + 1'b1) : b;
		r.neg_res = a_neg ^ b_neg;
		r.neg_a = a_neg;

		if (kind_t'(kind) == OP_NOP) begin
			r.err = ERR_NONE;
		end else if (a_tag == 2'd3 || b_tag == 2'd3) begin
			r.err = ERR_UNDEF;
		end else begin
			unique case (kind_t'(kind))
				OP_ADD: begin
					if (a_fin && b_fin) begin
						if (a_neg == b_neg && sum[WIDTH-1] != a_neg) r.err = ERR_OVF;
						else r.value = sum;
					end else if (a_fin) r.tag = b_tag;
					else if (b_fin || a_tag == b_tag) r.tag = a_tag;
					else r.err = ERR_UNDEF;
				end
				OP_SUB: begin
					if (a_fin && b_fin) begin
						if (a_neg != b_neg && dif[WIDTH-1] != a_neg) r.err = ERR_OVF;
						else r.value = dif;
					end else if (a_fin) r.tag = flip(b_tag);
					else if (b_fin || a_tag != b_tag) r.tag = a_tag;
					else r.err = ERR_UNDEF;
				end
				OP_MUL: begin
					if (a_fin && b_fin) r.op_mul = 1'b1;
					else if (a_fin) begin
						if (!a_zero) r.tag = a_neg ? flip(b_tag) : b_tag;
					end else if (b_fin) begin
						if (!b_zero) r.tag = b_neg ? flip(a_tag) : a_tag;
					end else r.tag = (a_tag == b_tag) ? TAG_POS : TAG_NEG;
				end
				OP_DIV, OP_MOD: begin
					if (a_fin && b_fin) begin
						if (b_zero) r.err = ERR_DIV0;
						else if (a == MIN_VAL && b == ALL_ONES) r.err = ERR_OVF;
						else begin
							r.op_div = 1'b1;
							r.op_rem = (kind_t'(kind) == OP_MOD);
						end
					end else if (a_fin) begin
						if (kind_t'(kind) == OP_MOD) r.value = a;
					end else if (kind_t'(kind) == OP_MOD) r.err = ERR_UNDEF;
					else if (b_fin) begin
						if (b_zero) r.err = ERR_DIV0;
						else r.tag = b_neg ? flip(a_tag) : a_tag;
					end else r.err = ERR_UNDEF;
				end
				OP_LESS: begin
					if (a_fin && b_fin) r.cmp = ($signed(a) < $signed(b));
					else if (a_tag == TAG_NEG) r.cmp = (b_tag != TAG_NEG);
					else if (a_tag == TAG_POS) r.cmp = 1'b0;
					else r.cmp = (b_tag == TAG_POS);
				end
				OP_EQ: r.cmp = (a_tag == b_tag) && (a == b);
				OP_NOP: r.err = ERR_NONE;
				default: r.err = ERR_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s1 <= r;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/eia_mul.sv
// Four-stage magnitude multiplier: 32x32 partial products, middle sum,
// full 128-bit sum, then overflow check and sign. Depends on eia_pkg.
`default_nettype none
module eia_mul import eia_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vld_i,
	input wire pipe_t rec_i,
	output logic vld_s4,
	output pipe_t rec_s4
);
	localparam int H = WIDTH / 2;

	logic vld_s1, vld_s2, vld_s3;
	pipe_t rec_s1, rec_s2, rec_s3, r4;
	logic [WIDTH-1:0] ll_s1, lh_s1, hl_s1, hh_s1, ll_s2, hh_s2;
	logic [WIDTH:0] mid_s2;
	logic [2*WIDTH-1:0] full_s3;
	logic ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_comb begin
		r4 = rec_s3;
		if (full_s3[2*WIDTH-1:WIDTH] != '0) ovf = 1'b1;
		else if (rec_s3.neg_res) ovf = (full_s3[WIDTH-1:0] > MIN_VAL);
		else ovf = full_s3[WIDTH-1];
		if (rec_s3.op_mul) begin
			if (ovf) begin
				r4.err = ERR_OVF;
				r4.value = '0;
			end else begin
				r4.value = rec_s3.neg_res ? (~full_s3[WIDTH-1:0] + 1'b1)
					: full_s3[WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s1 <= rec_i;
			ll_s1 <= rec_i.ua[H-1:0] * rec_i.ub[H-1:0];
			lh_s1 <= rec_i.ua[H-1:0] * rec_i.ub[WIDTH-1:H];
			hl_s1 <= rec_i.ua[WIDTH-1:H] * rec_i.ub[H-1:0];
			hh_s1 <= rec_i.ua[WIDTH-1:H] * rec_i.ub[WIDTH-1:H];
			rec_s2 <= rec_s1;
			mid_s2 <= {1'b0, lh_s1} + {1'b0, hl_s1};
			ll_s2 <= ll_s1;
			hh_s2 <= hh_s1;
			rec_s3 <= rec_s2;
			full_s3 <= {hh_s2, ll_s2} + {{(H-1){1'b0}}, mid_s2, {H{1'b0}}};
			rec_s4 <= r4;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/eia_div_step.sv
// One registered step of restoring division on magnitudes: ua shifts the
// dividend out and the quotient in, rr holds the partial remainder.
// Depends on eia_pkg.
`default_nettype none
module eia_div_step import eia_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vld_i,
	input wire pipe_t rec_i,
	output logic vld_s1,
	output pipe_t rec_s1
);
	logic [WIDTH:0] trial, diff;
	logic ge;
	pipe_t r;

	always_comb begin
		trial = {rec_i.rr, rec_i.ua[WIDTH-1]};
		diff = trial - {1'b0, rec_i.ub};
		ge = (trial >= {1'b0, rec_i.ub});
		r = rec_i;
		r.rr = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
		r.ua = {rec_i.ua[WIDTH-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s1 <= r;
		end
	end
endmodule
`default_nettype wire

>>> verif/tb_extended_integer_alu.sv
// Testbench for the extended integer ALU: a predictor of each request's result,
// random and directed requests, random stalls on both channels.
// Depends on eia_pkg, eia_in_if, eia_out_if and extended_integer_alu.
`default_nettype none
module tb_extended_integer_alu;
	import eia_pkg::*;

	typedef struct {
		logic [2:0] kind;
		logic signed [63:0] a_value;
		logic [1:0] a_tag;
		logic signed [63:0] b_value;
		logic [1:0] b_tag;
	} request_t;

	typedef struct {
		logic signed [63:0] res_value;
		logic [1:0] res_tag;
		logic cmp_true;
		logic [1:0] error_code;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit failed = 1'b0;
	bit stim_done = 1'b0;
	bit calm = 1'b0;          // no idling in the last part of the run

	request_t pending_reqs[$];
	result_t expected_results[$];

	eia_in_if req ();
	eia_out_if rsp ();

	extended_integer_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always #4 clk = ~clk;

	localparam logic signed [63:0] MAXV = 64'sh7fffffffffffffff;
	localparam logic signed [63:0] MINV = 64'sh8000000000000000;

	function automatic result_t make_result(logic signed [63:0] v, logic [1:0] t,
			logic c, logic [1:0] e);
		result_t r;
		r.res_value = v;
		r.res_tag = t;
		r.cmp_true = c;
		r.error_code = e;
		return r;
	endfunction

	function automatic logic [1:0] flip_tag(logic [1:0] t);
		return (t == TAG_POS) ? TAG_NEG : TAG_POS;
	endfunction

	// infinity of tag t with its sign turned by the sign of finite v; zero stays finite zero
	function automatic result_t scaled_inf(logic [1:0] t, logic signed [63:0] v);
		if (v == 0)
			return make_result(0, TAG_FIN, 1'b0, ERR_NONE);
		return make_result(0, (v > 0) ? t : flip_tag(t), 1'b0, ERR_NONE);
	endfunction

	function automatic result_t alu_result(request_t q);
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [64:0] wide;
		logic signed [127:0] prod;
		logic [1:0] ta;
		logic [1:0] tb;
		result_t fin0;
		result_t undef;
		fin0 = make_result(0, TAG_FIN, 1'b0, ERR_NONE);
		undef = make_result(0, TAG_FIN, 1'b0, ERR_UNDEF);
		ta = q.a_tag;
		tb = q.b_tag;
		// value field of an infinity is ignored
		a = (ta == TAG_FIN) ? q.a_value : 64'sd0;
		b = (tb == TAG_FIN) ? q.b_value : 64'sd0;
		if (q.kind == OP_NOP)
			return fin0;
		if (ta > TAG_NEG || tb > TAG_NEG)
			return undef;
		case (q.kind)
			OP_ADD, OP_SUB: begin
				if (ta == TAG_FIN && tb == TAG_FIN) begin
					wide = (q.kind == OP_ADD) ? ({a[63], a} + {b[63], b})
						: ({a[63], a} - {b[63], b});
					if (wide[64] != wide[63])
						return make_result(0, TAG_FIN, 1'b0, ERR_OVF);
					return make_result(wide[63:0], TAG_FIN, 1'b0, ERR_NONE);
				end
				if (ta == TAG_FIN)
					return make_result(0, (q.kind == OP_ADD) ? tb : flip_tag(tb), 1'b0,
						ERR_NONE);
				if (tb == TAG_FIN || ((q.kind == OP_ADD) == (ta == tb)))
					return make_result(0, ta, 1'b0, ERR_NONE);
				return undef;
			end
			OP_MUL: begin
				if (ta == TAG_FIN && tb == TAG_FIN) begin
					prod = 128'(a) * 128'(b);
					if (prod > 128'(MAXV) || prod < 128'(MINV))
						return make_result(0, TAG_FIN, 1'b0, ERR_OVF);
					return make_result(prod[63:0], TAG_FIN, 1'b0, ERR_NONE);
				end
				if (ta == TAG_FIN)
					return scaled_inf(tb, a);
				if (tb == TAG_FIN)
					return scaled_inf(ta, b);
				return make_result(0, (ta == tb) ? TAG_POS : TAG_NEG, 1'b0, ERR_NONE);
			end
			OP_DIV, OP_MOD: begin
				if (ta == TAG_FIN && tb == TAG_FIN) begin
					if (b == 0)
						return make_result(0, TAG_FIN, 1'b0, ERR_DIV0);
					if (a == MINV && b == -64'sd1)
						return make_result(0, TAG_FIN, 1'b0, ERR_OVF);
					return make_result((q.kind == OP_MOD) ? a % b : a / b, TAG_FIN,
						1'b0, ERR_NONE);
				end
				if (ta == TAG_FIN)
					return make_result((q.kind == OP_MOD) ? a : 64'sd0, TAG_FIN, 1'b0,
						ERR_NONE);
				if (q.kind == OP_MOD)
					return undef;
				if (tb == TAG_FIN) begin
					if (b == 0)
						return make_result(0, TAG_FIN, 1'b0, ERR_DIV0);
					return scaled_inf(ta, b);
				end
				return undef;
			end
			OP_LESS: begin
				// -inf below everything, +inf above everything
				if (ta == TAG_FIN && tb == TAG_FIN)
					return make_result(0, TAG_FIN, a < b, ERR_NONE);
				if (ta == TAG_NEG)
					return make_result(0, TAG_FIN, tb != TAG_NEG, ERR_NONE);
				if (ta == TAG_POS)
					return fin0;
				return make_result(0, TAG_FIN, tb == TAG_POS, ERR_NONE);
			end
			default:
				return make_result(0, TAG_FIN, (ta == tb) && (a == b), ERR_NONE);
		endcase
	endfunction

	function automatic logic signed [63:0] rand_value();
		case ($urandom_range(0, 9))
			0: return MAXV;
			1: return MINV;
			2: return 64'sd0;
			3: return -64'sd1;
			4: return 64'($signed($urandom_range(0, 20)) - 10);
			5: return 64'($signed($urandom()));
			6: return {$urandom(), $urandom()} >>> $urandom_range(0, 62);
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic request_t rand_request();
		request_t q;
		q.kind = 3'($urandom_range(0, 7));
		q.a_tag = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : TAG_FIN;
		q.b_tag = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : TAG_FIN;
		q.a_value = rand_value();
		q.b_value = rand_value();
		// multiply with small operands so that products stay in range often
		if (q.kind == OP_MUL && $urandom_range(0, 1)) begin
			q.a_value = q.a_value >>> 32;
			q.b_value = q.b_value >>> 31;
		end
		// some division results exercise the most negative over minus one case
		if (q.kind inside {OP_DIV, OP_MOD} && $urandom_range(0, 15) == 0) begin
			q.a_value = MINV;
			q.b_value = -64'sd1;
		end
		// equality hits need equal operands
		if (q.kind == OP_EQ && $urandom_range(0, 1)) begin
			q.b_value = q.a_value;
			q.b_tag = q.a_tag;
		end
		// an infinity usually has a zero value field, sometimes garbage
		if (q.a_tag != TAG_FIN && $urandom_range(0, 2) != 0)
			q.a_value = 0;
		if (q.b_tag != TAG_FIN && $urandom_range(0, 2) != 0)
			q.b_value = 0;
		return q;
	endfunction

	task automatic add_request(logic [2:0] k, logic signed [63:0] av, logic [1:0] at,
			logic signed [63:0] bv, logic [1:0] bt);
		request_t q;
		q.kind = k;
		q.a_value = av;
		q.a_tag = at;
		q.b_value = bv;
		q.b_tag = bt;
		pending_reqs.push_back(q);
	endtask

	// stimulus: directed corner cases, then random requests
	initial begin
		add_request(OP_ADD, MAXV, TAG_FIN, 64'sd1, TAG_FIN);
		add_request(OP_ADD, MINV, TAG_FIN, -64'sd1, TAG_FIN);
		add_request(OP_ADD, 0, TAG_POS, 0, TAG_NEG);
		add_request(OP_ADD, 64'sd5, TAG_FIN, 0, TAG_NEG);
		add_request(OP_SUB, MINV, TAG_FIN, 64'sd1, TAG_FIN);
		add_request(OP_SUB, 0, TAG_FIN, MINV, TAG_FIN);
		add_request(OP_SUB, 0, TAG_POS, 0, TAG_POS);
		add_request(OP_SUB, 0, TAG_FIN, 0, TAG_POS);
		add_request(OP_MUL, MAXV, TAG_FIN, -64'sd1, TAG_FIN);
		add_request(OP_MUL, MINV, TAG_FIN, -64'sd1, TAG_FIN);
		add_request(OP_MUL, 0, TAG_FIN, 0, TAG_NEG);
		add_request(OP_MUL, -64'sd3, TAG_FIN, 0, TAG_POS);
		add_request(OP_MUL, 0, TAG_NEG, 0, TAG_NEG);
		add_request(OP_DIV, MINV, TAG_FIN, -64'sd1, TAG_FIN);
		add_request(OP_DIV, 64'sd7, TAG_FIN, 0, TAG_FIN);
		add_request(OP_DIV, -64'sd7, TAG_FIN, 0, TAG_POS);
		add_request(OP_DIV, 0, TAG_POS, -64'sd2, TAG_FIN);
		add_request(OP_DIV, 0, TAG_NEG, 0, TAG_FIN);
		add_request(OP_DIV, 0, TAG_POS, 0, TAG_NEG);
		add_request(OP_MOD, -64'sd7, TAG_FIN, 64'sd2, TAG_FIN);
		add_request(OP_MOD, MINV, TAG_FIN, -64'sd1, TAG_FIN);
		add_request(OP_MOD, 0, TAG_POS, 64'sd3, TAG_FIN);
		add_request(OP_LESS, 0, TAG_POS, 0, TAG_POS);
		add_request(OP_EQ, 64'sd9, TAG_NEG, 64'sd4, TAG_NEG);
		add_request(OP_NOP, MAXV, 2'd3, MINV, 2'd3);
		repeat (1350)
			pending_reqs.push_back(rand_request());
		stim_done = 1'b1;
	end

	// driver: pop a request when the channel is free, idle in random bursts
	int send_idle = 0;
	initial begin
		req.valid = 1'b0;
		req.kind = OP_ADD;
		req.a_value = '0;
		req.a_tag = TAG_FIN;
		req.b_value = '0;
		req.b_tag = TAG_FIN;
		rsp.ready = 1'b0;
	end

	always @(posedge clk) begin
		request_t q;
		if (arst_n) begin
			if (!req.valid || req.ready) begin
				if (req.valid)
					expected_results.push_back(alu_result(pending_reqs.pop_front()));
				if (send_idle > 0) begin
					send_idle <= send_idle - 1;
					req.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					// this cycle idles too, ahead of the send_idle count drawn here
					send_idle <= $urandom_range(0, 10);
					req.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					q = pending_reqs[0];
					req.valid <= 1'b1;
					req.kind <= q.kind;
					req.a_value <= q.a_value;
					req.a_tag <= q.a_tag;
					req.b_value <= q.b_value;
					req.b_tag <= q.b_tag;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// the last couple hundred requests go through with no idling
	always @(posedge clk)
		if (stim_done && pending_reqs.size() < 200)
			calm <= 1'b1;

	// monitor: compare each result against the oldest expectation
	int recv_idle = 0;
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected: value %0d tag %0d",
						$time, rsp.res_value, rsp.res_tag);
					failed = 1'b1;
				end else begin
					exp_r = expected_results.pop_front();
					if (rsp.res_value !== exp_r.res_value) begin
						$display("%0t: res_value expected %0d actual %0d", $time,
							exp_r.res_value, rsp.res_value);
						failed = 1'b1;
					end
					if (rsp.res_tag !== exp_r.res_tag) begin
						$display("%0t: res_tag expected %0d actual %0d", $time,
							exp_r.res_tag, rsp.res_tag);
						failed = 1'b1;
					end
					if (rsp.cmp_true !== exp_r.cmp_true) begin
						$display("%0t: cmp_true expected %0d actual %0d", $time,
							exp_r.cmp_true, rsp.cmp_true);
						failed = 1'b1;
					end
					if (rsp.error_code !== exp_r.error_code) begin
						$display("%0t: error_code expected %0d actual %0d", $time,
							exp_r.error_code, rsp.error_code);
						failed = 1'b1;
					end
				end
			end
			if (recv_idle > 0) begin
				recv_idle <= recv_idle - 1;
				rsp.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				recv_idle <= $urandom_range(0, 10);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// reset, then wait for the pipeline to drain
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && pending_reqs.size() == 0 && !req.valid);
		wait (expected_results.size() == 0);
		repeat (100) @(posedge clk);
		if (!failed)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
